// ===== hdl/hicc_pkg.sv =====
package hicc_pkg;

   // Payload and register types.
   typedef logic signed [10:0] temp_type;
   typedef logic        [9:0]  humid_type;
   typedef logic signed [11:0] hi_type;
   typedef logic signed [12:0] hi_full_type;
   typedef logic        [2:0]  level_type;
   typedef logic        [2:0]  csr_index_type;
   typedef logic        [11:0] csr_data_type;

   // Configuration register indexes.
   localparam csr_index_type CSR_VALID_TEMP_MIN     = 3'd0;
   localparam csr_index_type CSR_VALID_HUMIDITY_MIN = 3'd1;
   localparam csr_index_type CSR_COLD_LIMIT         = 3'd2;
   localparam csr_index_type CSR_COOL_LIMIT         = 3'd3;
   localparam csr_index_type CSR_COMFORTABLE_LIMIT  = 3'd4;
   localparam csr_index_type CSR_WARM_LIMIT         = 3'd5;

   // Comfort levels.
   localparam level_type LEVEL_COLD        = 3'd0;
   localparam level_type LEVEL_COOL        = 3'd1;
   localparam level_type LEVEL_COMFORTABLE = 3'd2;
   localparam level_type LEVEL_WARM        = 3'd3;
   localparam level_type LEVEL_HOT         = 3'd4;

   typedef struct packed {
      temp_type  valid_temp_min;
      humid_type valid_humidity_min;
      hi_type    cold_limit;
      hi_type    cool_limit;
      hi_type    comfortable_limit;
      hi_type    warm_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      valid_temp_min:     11'sd200,
      valid_humidity_min: 10'd400,
      cold_limit:         12'sd100,
      cool_limit:         12'sd200,
      comfortable_limit:  12'sd280,
      warm_limit:         12'sd350
   };

   localparam int COEF_FRAC_BITS_DEFAULT = 24;

   // Regression coefficients scaled by 2^32, rounded to nearest.
   localparam longint COEF_SCALED_32 [9] = '{
      64'sd37729976680,
      64'sd6920885003,
      64'sd10043990783,
      64'sd627563656,
      64'sd52862861,
      64'sd70544099,
      64'sd9499317,
      64'sd3115827,
      64'sd15385
   };

   // Heat index limits in tenths.
   localparam int HI_MIN = -1000;
   localparam int HI_MAX = 2000;

   // The rounded heat index is held in [HI_CLAMP_LO, HI_CLAMP_HI], which lies
   // beyond every 12 bit threshold, so classification is unaffected.
   localparam int HI_CLAMP_LO = -2049;
   localparam int HI_CLAMP_HI = 2048;

   // Floor division of the scaled sum by 1000 * 2^F: the power of two is a
   // shift, the thousand a reciprocal multiply.
   localparam longint DIV_SCALE   = 1000;
   localparam longint DIV_LO      = longint'(HI_CLAMP_LO) * DIV_SCALE;
   localparam longint DIV_HI      = longint'(HI_CLAMP_HI) * DIV_SCALE + DIV_SCALE - 1;
   localparam int     DIV_IN_W    = 22;
   localparam int     RECIP_SHIFT = 32;
   localparam longint RECIP_MULT  = ((longint'(1) << RECIP_SHIFT) + DIV_SCALE - 1) / DIV_SCALE;
   localparam int     RECIP_W     = 23;
   localparam int     PROD_W      = DIV_IN_W + RECIP_W;
   localparam int     QUOT_W      = PROD_W - RECIP_SHIFT;

   // Coefficient k scaled by 2^frac, rounding half up.
   function automatic longint coef_fix(input logic [3:0] k, input int frac);
      longint raw;
      int     s;
      raw = COEF_SCALED_32[k];
      s   = 32 - frac;
      if (s <= 0) begin
         return raw;
      end
      return (raw + (longint'(1) << (s - 1))) >>> s;
   endfunction

endpackage

// ===== hdl/hicc_if.sv =====
interface hicc_req_if;
   import hicc_pkg::*;

   logic      valid;
   logic      ready;
   temp_type  temperature_tenths;
   humid_type humidity_tenths;

   modport source (output valid, output temperature_tenths, output humidity_tenths,
                   input ready);
   modport sink   (input valid, input temperature_tenths, input humidity_tenths,
                   output ready);
endinterface

interface hicc_rsp_if;
   import hicc_pkg::*;

   logic      valid;
   logic      ready;
   hi_type    heat_index_tenths;
   level_type comfort_level;
   logic      saturated;

   modport source (output valid, output heat_index_tenths, output comfort_level,
                   output saturated, input ready);
   modport sink   (input valid, input heat_index_tenths, input comfort_level,
                   input saturated, output ready);
endinterface

interface hicc_csr_if;
   import hicc_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/heat_index_comfort_classifier.sv =====
// A result reaches the response side once it has passed through stages 1 to 9 in order.
// Throughput: one transaction per cycle while results are being accepted; each of the nine
// pipeline stages holds one item and a stage loads whenever the stage after it can take
// its contents. The output stage is a register, so requests keep flowing into empty stages
// while a finished result waits for its response transaction.
// Reset (synchronous): all stage valid bits clear and the configuration registers take their defaults.
module heat_index_comfort_classifier #(
   parameter int COEF_FRAC_BITS = hicc_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   hicc_req_if.sink   req_if,
   hicc_rsp_if.source rsp_if,
   hicc_csr_if.sink   csr_if
);
   import hicc_pkg::*;

   // Coefficients in fixed point, with the decimal scaling of each term folded in.
   // The regression sum is S = Bias + K1*t + K2*r - K3*t*r - K4*t^2 - K5*r^2
   //    + K6*t^2*r + K7*t*r^2 - C8*t^2*r^2, where t and r are raw tenths and
   // Bias already carries half the final divisor for rounding.
   localparam longint C0      = coef_fix(4'd0, COEF_FRAC_BITS);
   localparam longint K1      = 1000 * coef_fix(4'd1, COEF_FRAC_BITS);
   localparam longint K2      = 1000 * coef_fix(4'd2, COEF_FRAC_BITS);
   localparam longint K3      = 100 * coef_fix(4'd3, COEF_FRAC_BITS);
   localparam longint K4      = 100 * coef_fix(4'd4, COEF_FRAC_BITS);
   localparam longint K5      = 100 * coef_fix(4'd5, COEF_FRAC_BITS);
   localparam longint K6      = 10 * coef_fix(4'd6, COEF_FRAC_BITS);
   localparam longint K7      = 10 * coef_fix(4'd7, COEF_FRAC_BITS);
   localparam longint C8      = coef_fix(4'd8, COEF_FRAC_BITS);
   localparam longint HalfDiv = 500 * (longint'(1) << COEF_FRAC_BITS);
   localparam longint Bias    = HalfDiv - 10000 * C0;

   localparam int NumStages = 9;

   // ---------------------------------------------------------------------
   // Configuration registers. The port never stalls; writes beyond the
   // register list are dropped.
   // ---------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            CSR_VALID_TEMP_MIN:     cfg_in.valid_temp_min     = temp_type'(csr_if.data[10:0]);
            CSR_VALID_HUMIDITY_MIN: cfg_in.valid_humidity_min = csr_if.data[9:0];
            CSR_COLD_LIMIT:         cfg_in.cold_limit         = hi_type'(csr_if.data);
            CSR_COOL_LIMIT:         cfg_in.cool_limit         = hi_type'(csr_if.data);
            CSR_COMFORTABLE_LIMIT:  cfg_in.comfortable_limit  = hi_type'(csr_if.data);
            CSR_WARM_LIMIT:         cfg_in.warm_limit         = hi_type'(csr_if.data);
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage contents. The enable flag (regression or pass-through) and the
   // raw temperature travel alongside the arithmetic.
   // ---------------------------------------------------------------------
   typedef struct packed {
      logic               en;
      temp_type           t;
      humid_type          r;
      logic signed [21:0] tt;
      logic signed [21:0] tr;
      logic        [19:0] rr;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
   } s1_type;

   typedef struct packed {
      logic               en;
      temp_type           t;
      logic        [19:0] rr;
      logic signed [32:0] ttr;
      logic signed [31:0] trr;
      logic signed [37:0] q8;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] p3;
      logic signed [63:0] p4;
      logic signed [63:0] p5;
   } s2_type;

   typedef struct packed {
      logic               en;
      temp_type           t;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic signed [63:0] p3;
      logic signed [63:0] p4;
      logic signed [63:0] p5;
      logic signed [63:0] p6;
      logic signed [63:0] p7;
      logic signed [63:0] p8;
   } s3_type;

   typedef struct packed {
      logic               en;
      temp_type           t;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
      logic signed [63:0] d;
      logic signed [63:0] e;
   } s4_type;

   typedef struct packed {
      logic               en;
      temp_type           t;
      logic signed [63:0] u0;
      logic signed [63:0] u1;
      logic signed [63:0] u2;
   } s5_type;

   typedef struct packed {
      logic               en;
      temp_type           t;
      logic signed [63:0] sum;
   } s6_type;

   typedef struct packed {
      logic                en;
      temp_type            t;
      logic [DIV_IN_W-1:0] n;
   } s7_type;

   typedef struct packed {
      logic              en;
      temp_type          t;
      logic [QUOT_W-1:0] quot;
   } s8_type;

   typedef struct packed {
      hi_type    hi_tenths;
      level_type level;
      logic      sat;
   } s9_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;
   s9_type s9_ff, s9_in;

   // ---------------------------------------------------------------------
   // Flow control. A stage may load when it is empty or when the stage
   // after it loads in the same cycle, so bubbles are squeezed out even
   // while the output register is held.
   // ---------------------------------------------------------------------
   logic [NumStages-1:0] stage_v_ff, stage_v_in;
   logic [NumStages-1:0] stage_rdy;

   assign stage_rdy[NumStages-1] = !stage_v_ff[NumStages-1] || rsp_if.ready;

   for (genvar i = 0; i < NumStages - 1; i++) begin : g_rdy
      assign stage_rdy[i] = !stage_v_ff[i] || stage_rdy[i+1];
   end

   assign stage_v_in   = {stage_v_ff[NumStages-2:0], req_if.valid};
   assign req_if.ready = stage_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= '0;
      end else begin
         stage_v_ff <= (stage_rdy & stage_v_in) | (~stage_rdy & stage_v_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: validity test, squares and cross product of the inputs, and
   // the two linear terms.
   // ---------------------------------------------------------------------
   logic signed [10:0] r_s;

   assign r_s = $signed({1'b0, req_if.humidity_tenths});

   always_comb begin
      s1_in.en = (req_if.temperature_tenths >= cfg_ff.valid_temp_min) &&
                 (req_if.humidity_tenths >= cfg_ff.valid_humidity_min);
      s1_in.t  = req_if.temperature_tenths;
      s1_in.r  = req_if.humidity_tenths;
      s1_in.tt = 22'(req_if.temperature_tenths) * 22'(req_if.temperature_tenths);
      s1_in.tr = 22'(req_if.temperature_tenths) * 22'(r_s);
      s1_in.rr = 20'(req_if.humidity_tenths) * 20'(req_if.humidity_tenths);
      s1_in.p1 = K1 * 64'(req_if.temperature_tenths);
      s1_in.p2 = K2 * 64'(r_s);
   end

   // ---------------------------------------------------------------------
   // Stage 2: third-order monomials, the quadratic terms, and the first
   // half of the fourth-order term.
   // ---------------------------------------------------------------------
   logic signed [10:0] s1_r_s;
   logic signed [20:0] s1_rr_s;

   assign s1_r_s  = $signed({1'b0, s1_ff.r});
   assign s1_rr_s = $signed({1'b0, s1_ff.rr});

   always_comb begin
      s2_in.en  = s1_ff.en;
      s2_in.t   = s1_ff.t;
      s2_in.rr  = s1_ff.rr;
      s2_in.ttr = 33'(s1_ff.tt) * 33'(s1_r_s);
      s2_in.trr = 32'(s1_ff.t) * 32'(s1_rr_s);
      s2_in.q8  = 38'(C8) * 38'(s1_ff.tt);
      s2_in.p1  = s1_ff.p1;
      s2_in.p2  = s1_ff.p2;
      s2_in.p3  = K3 * 64'(s1_ff.tr);
      s2_in.p4  = K4 * 64'(s1_ff.tt);
      s2_in.p5  = K5 * 64'(s1_rr_s);
   end

   // ---------------------------------------------------------------------
   // Stage 3: the cubic terms and the quartic term.
   // ---------------------------------------------------------------------
   logic signed [20:0] s2_rr_s;
   logic signed [58:0] p8_full;

   assign s2_rr_s = $signed({1'b0, s2_ff.rr});
   assign p8_full = 59'(s2_ff.q8) * 59'(s2_rr_s);

   always_comb begin
      s3_in.en = s2_ff.en;
      s3_in.t  = s2_ff.t;
      s3_in.p1 = s2_ff.p1;
      s3_in.p2 = s2_ff.p2;
      s3_in.p3 = s2_ff.p3;
      s3_in.p4 = s2_ff.p4;
      s3_in.p5 = s2_ff.p5;
      s3_in.p6 = K6 * 64'(s2_ff.ttr);
      s3_in.p7 = K7 * 64'(s2_ff.trr);
      s3_in.p8 = 64'(p8_full);
   end

   // ---------------------------------------------------------------------
   // Stages 4 to 6: the nine-term sum as a registered adder tree. Terms
   // that enter negatively are subtracted at the level where they meet.
   // ---------------------------------------------------------------------
   always_comb begin
      s4_in.en = s3_ff.en;
      s4_in.t  = s3_ff.t;
      s4_in.a  = s3_ff.p1 + s3_ff.p2;
      s4_in.b  = Bias - s3_ff.p3;
      s4_in.c  = s3_ff.p4 + s3_ff.p5;
      s4_in.d  = s3_ff.p6 + s3_ff.p7;
      s4_in.e  = s3_ff.p8;
   end

   always_comb begin
      s5_in.en = s4_ff.en;
      s5_in.t  = s4_ff.t;
      s5_in.u0 = s4_ff.a + s4_ff.b;
      s5_in.u1 = s4_ff.d - s4_ff.c;
      s5_in.u2 = s4_ff.e;
   end

   always_comb begin
      s6_in.en  = s5_ff.en;
      s6_in.t   = s5_ff.t;
      s6_in.sum = s5_ff.u0 + s5_ff.u1 - s5_ff.u2;
   end

   // ---------------------------------------------------------------------
   // Stage 7: floor division by the power of two is an arithmetic shift.
   // The quotient is then clamped to a window wider than every threshold
   // and offset to be non-negative for the divide by one thousand.
   // ---------------------------------------------------------------------
   logic signed [63:0] q0;
   logic signed [63:0] qc;

   always_comb begin
      q0 = s6_ff.sum >>> COEF_FRAC_BITS;
      if (q0 < DIV_LO) begin
         qc = DIV_LO;
      end else if (q0 > DIV_HI) begin
         qc = DIV_HI;
      end else begin
         qc = q0;
      end
      s7_in.en = s6_ff.en;
      s7_in.t  = s6_ff.t;
      s7_in.n  = DIV_IN_W'(qc - DIV_LO);
   end

   // ---------------------------------------------------------------------
   // Stage 8: divide by one thousand through the rounded-up reciprocal,
   // which is exact for every value the offset window can produce.
   // ---------------------------------------------------------------------
   logic [PROD_W-1:0] div_prod;

   assign div_prod = PROD_W'(s7_ff.n) * PROD_W'(RECIP_MULT);

   always_comb begin
      s8_in.en   = s7_ff.en;
      s8_in.t    = s7_ff.t;
      s8_in.quot = div_prod[RECIP_SHIFT +: QUOT_W];
   end

   // ---------------------------------------------------------------------
   // Stage 9 (output register): remove the offset, choose between the
   // regression and the raw temperature, classify on the unsaturated value
   // and saturate.
   // ---------------------------------------------------------------------
   logic signed [QUOT_W:0] hi_wide;
   hi_full_type            hi_full;

   assign hi_wide = $signed({1'b0, s8_ff.quot}) + (QUOT_W + 1)'(HI_CLAMP_LO);

   always_comb begin
      hi_full = s8_ff.en ? hi_full_type'(hi_wide) : hi_full_type'(s8_ff.t);

      if (hi_full < hi_full_type'(cfg_ff.cold_limit)) begin
         s9_in.level = LEVEL_COLD;
      end else if (hi_full < hi_full_type'(cfg_ff.cool_limit)) begin
         s9_in.level = LEVEL_COOL;
      end else if (hi_full < hi_full_type'(cfg_ff.comfortable_limit)) begin
         s9_in.level = LEVEL_COMFORTABLE;
      end else if (hi_full < hi_full_type'(cfg_ff.warm_limit)) begin
         s9_in.level = LEVEL_WARM;
      end else begin
         s9_in.level = LEVEL_HOT;
      end

      if (hi_full < hi_full_type'(HI_MIN)) begin
         s9_in.hi_tenths = hi_type'(HI_MIN);
         s9_in.sat       = 1'b1;
      end else if (hi_full > hi_full_type'(HI_MAX)) begin
         s9_in.hi_tenths = hi_type'(HI_MAX);
         s9_in.sat       = 1'b1;
      end else begin
         s9_in.hi_tenths = hi_type'(hi_full);
         s9_in.sat       = 1'b0;
      end
   end

   // Stage data registers: loaded whenever the stage may load; the valid
   // bits above decide whether the contents mean anything.
   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         s1_ff <= s1_in;
      end
      if (stage_rdy[1]) begin
         s2_ff <= s2_in;
      end
      if (stage_rdy[2]) begin
         s3_ff <= s3_in;
      end
      if (stage_rdy[3]) begin
         s4_ff <= s4_in;
      end
      if (stage_rdy[4]) begin
         s5_ff <= s5_in;
      end
      if (stage_rdy[5]) begin
         s6_ff <= s6_in;
      end
      if (stage_rdy[6]) begin
         s7_ff <= s7_in;
      end
      if (stage_rdy[7]) begin
         s8_ff <= s8_in;
      end
      if (stage_rdy[8]) begin
         s9_ff <= s9_in;
      end
   end

   assign rsp_if.valid             = stage_v_ff[NumStages-1];
   assign rsp_if.heat_index_tenths = s9_ff.hi_tenths;
   assign rsp_if.comfort_level     = s9_ff.level;
   assign rsp_if.saturated         = s9_ff.sat;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------

   // Requests are refused only when every stage is occupied.
   a_full_when_refused: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&stage_v_ff))
      else $error("request refused while a pipeline stage is empty");

   // An accepted request occupies the first stage on the next cycle.
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> stage_v_ff[0])
      else $error("accepted request did not enter the first stage");

   // A saturated result sits exactly on one of the range limits.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.saturated) |->
         (rsp_if.heat_index_tenths == hi_type'(HI_MIN) ||
          rsp_if.heat_index_tenths == hi_type'(HI_MAX)))
      else $error("saturated result is not at a range limit");

   // Reset restores every configuration register to its default.
   a_cfg_reset: assert property (@(posedge clock)
      reset |=> (cfg_ff == CFG_RESET))
      else $error("configuration registers not at defaults after reset");

endmodule

// ===== tb/sv/heat_index_comfort_classifier_tb.sv =====
`timescale 1ns / 100ps

import hicc_pkg::*;

// One expected response transaction.
typedef struct packed {
   hi_type    hi_tenths;
   level_type level;
   logic      clipped;
} comfort_verdict_type;

class comfort_scoreboard;
   localparam int FRAC_BITS = 24;
   localparam int HI_FLOOR  = -1000;
   localparam int HI_CEIL   = 2000;

   temp_type            min_temp;
   humid_type           min_humidity;
   hi_type              cold_limit;
   hi_type              cool_limit;
   hi_type              comfortable_limit;
   hi_type              warm_limit;
   comfort_verdict_type verdict_due[$];
   int                  mismatch_count;

   function new();
      min_temp          = 11'sd200;
      min_humidity      = 10'd400;
      cold_limit        = 12'sd100;
      cool_limit        = 12'sd200;
      comfortable_limit = 12'sd280;
      warm_limit        = 12'sd350;
      mismatch_count    = 0;
   endfunction

   // Regression coefficient k at FRAC_BITS fractional bits, rounded half up
   // from its 2^32 scaled value.
   static function longint coefficient(int k);
      longint scaled32;
      case (k)
         0:       scaled32 = 64'sd37729976680;
         1:       scaled32 = 64'sd6920885003;
         2:       scaled32 = 64'sd10043990783;
         3:       scaled32 = 64'sd627563656;
         4:       scaled32 = 64'sd52862861;
         5:       scaled32 = 64'sd70544099;
         6:       scaled32 = 64'sd9499317;
         7:       scaled32 = 64'sd3115827;
         default: scaled32 = 64'sd15385;
      endcase
      return (scaled32 + (longint'(1) << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
   endfunction

   function void apply_register(csr_index_type reg_index, csr_data_type data);
      case (reg_index)
         CSR_VALID_TEMP_MIN:     min_temp          = temp_type'(data[10:0]);
         CSR_VALID_HUMIDITY_MIN: min_humidity      = humid_type'(data[9:0]);
         CSR_COLD_LIMIT:         cold_limit        = hi_type'(data);
         CSR_COOL_LIMIT:         cool_limit        = hi_type'(data);
         CSR_COMFORTABLE_LIMIT:  comfortable_limit = hi_type'(data);
         CSR_WARM_LIMIT:         warm_limit        = hi_type'(data);
         default: ;
      endcase
   endfunction

   function comfort_verdict_type predict_verdict(temp_type t_raw, humid_type r_raw);
      longint              c [9];
      longint              t;
      longint              r;
      longint              s;
      longint              d;
      longint              num;
      longint              hi;
      comfort_verdict_type v;
      for (int k = 0; k < 9; k++) begin
         c[k] = coefficient(k);
      end
      t = longint'(t_raw);
      r = longint'(r_raw);
      if (t >= longint'(min_temp) && r >= longint'(min_humidity)) begin
         s = - c[0] * 10000
             + c[1] * 1000 * t
             + c[2] * 1000 * r
             - c[3] * 100 * t * r
             - c[4] * 100 * t * t
             - c[5] * 100 * r * r
             + c[6] * 10 * t * t * r
             + c[7] * 10 * t * r * r
             - c[8] * t * t * r * r;
         d   = longint'(1000) * (longint'(1) << FRAC_BITS);
         num = s + d / 2;
         hi  = num / d;
         if ((num % d) != 0 && num < 0) begin
            hi = hi - 1;
         end
      end else begin
         hi = t;
      end

      // The level is taken from the heat index before it is clipped.
      if (hi < longint'(cold_limit)) begin
         v.level = LEVEL_COLD;
      end else if (hi < longint'(cool_limit)) begin
         v.level = LEVEL_COOL;
      end else if (hi < longint'(comfortable_limit)) begin
         v.level = LEVEL_COMFORTABLE;
      end else if (hi < longint'(warm_limit)) begin
         v.level = LEVEL_WARM;
      end else begin
         v.level = LEVEL_HOT;
      end

      v.clipped = 1'b0;
      if (hi < HI_FLOOR) begin
         hi        = HI_FLOOR;
         v.clipped = 1'b1;
      end
      if (hi > HI_CEIL) begin
         hi        = HI_CEIL;
         v.clipped = 1'b1;
      end
      v.hi_tenths = hi_type'(hi);
      return v;
   endfunction

   function void note_reading(temp_type t_raw, humid_type r_raw);
      verdict_due.push_back(predict_verdict(t_raw, r_raw));
   endfunction

   function void check_result(hi_type hi, level_type level, logic clipped);
      comfort_verdict_type want;
      if (verdict_due.size() == 0) begin
         $display("%0t: unexpected result heat index %0d level=%0d saturated=%0b",
                  $time, hi, level, clipped);
         mismatch_count++;
         return;
      end
      want = verdict_due.pop_front();
      if (hi !== want.hi_tenths) begin
         $display("%0t: heat_index_tenths expected %0d actual %0d", $time, want.hi_tenths, hi);
         mismatch_count++;
      end
      if (level !== want.level) begin
         $display("%0t: comfort_level expected %0d actual %0d", $time, want.level, level);
         mismatch_count++;
      end
      if (clipped !== want.clipped) begin
         $display("%0t: saturated expected %0b actual %0b", $time, want.clipped, clipped);
         mismatch_count++;
      end
   endfunction

   function int readings_in_flight();
      return verdict_due.size();
   endfunction
endclass

module heat_index_comfort_classifier_tb;

   // The settle time leaves some margin beyond the pipeline latency.
   localparam int SETTLE_CYCLES = 16;
   // The receiver holds off this long once, so that the pipeline fills and
   // the request channel is back-pressured.
   localparam int HOLD_CYCLES   = 120;
   localparam int PHASE_ITEMS   = 86;
   // The limit is several times the length of the slowest legal run.
   localparam int CYCLE_LIMIT   = 400000;

   // Register indexes beyond the list; writes to them must be ignored.
   localparam csr_index_type CSR_UNMAPPED_LO = CSR_WARM_LIMIT + 3'd1;
   localparam csr_index_type CSR_UNMAPPED_HI = CSR_WARM_LIMIT + 3'd2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Shared control between the stimulus, the receiver and the checker.
   bit                idle_on  = 1'b1;
   bit                hold_off = 1'b0;
   int                cycle_count = 0;
   comfort_scoreboard board;

   hicc_req_if req_bus ();
   hicc_rsp_if rsp_bus ();
   hicc_csr_if csr_bus ();

   heat_index_comfort_classifier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: a run that has not finished by the limit counts as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("heat_index_comfort_classifier_tb failed");
         $finish;
      end
   end

   // Every accepted response transaction is compared against the oldest
   // prediction still waiting. Values are read before the edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_result(rsp_bus.heat_index_tenths, rsp_bus.comfort_level,
                            rsp_bus.saturated);
      end
   end

   // Sender-side gap: mostly back to back, sometimes short, rarely long.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!idle_on || hold_off) begin
         return 0;
      end
      if (p < 60) begin
         return 0;
      end else if (p < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offers one reading and returns at the edge where the request transaction
   // is accepted. valid is only lowered when a gap follows, so back-to-back
   // transactions never see a low and a high in the same time step.
   task automatic offer_reading(input int t, input int r);
      int gap;
      req_bus.valid              <= 1'b1;
      req_bus.temperature_tenths <= temp_type'(t);
      req_bus.humidity_tenths    <= humid_type'(r);
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      board.note_reading(temp_type'(t), humid_type'(r));
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_readings();
      req_bus.valid <= 1'b0;
   endtask

   // Random reading: mostly the documented ranges, a share close to the
   // regression's entry limits, and some raw bit patterns of the full width.
   task automatic offer_random_reading();
      int p;
      int t;
      int r;
      p = $urandom_range(0, 99);
      if (p < 65) begin
         t = $urandom_range(0, 1200) - 400;
         r = $urandom_range(0, 1000);
      end else if (p < 85) begin
         t = int'(board.min_temp) + $urandom_range(0, 6) - 3;
         r = int'(board.min_humidity) + $urandom_range(0, 6) - 3;
      end else begin
         t = $urandom;
         r = $urandom;
      end
      offer_reading(t, r);
   endtask

   // Configuration writes keep valid high between back-to-back writes;
   // finish_csr lowers it once the burst is over.
   task automatic write_csr(input csr_index_type reg_index, input int value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data  <= csr_data_type'(value);
      do begin
         @(posedge clock);
      end while (csr_bus.ready !== 1'b1);
      board.apply_register(reg_index, csr_data_type'(value));
   endtask

   task automatic finish_csr();
      csr_bus.valid <= 1'b0;
   endtask

   task automatic program_all(input int temp_min, input int humid_min, input int cold,
                              input int cool, input int comfortable, input int warm);
      write_csr(CSR_VALID_TEMP_MIN, temp_min);
      write_csr(CSR_VALID_HUMIDITY_MIN, humid_min);
      write_csr(CSR_COLD_LIMIT, cold);
      write_csr(CSR_COOL_LIMIT, cool);
      write_csr(CSR_COMFORTABLE_LIMIT, comfortable);
      write_csr(CSR_WARM_LIMIT, warm);
      finish_csr();
   endtask

   // Waits until every predicted result has come back, then lets the
   // pipeline settle so that the block is idle before the next write.
   task automatic wait_drained();
      while (board.readings_in_flight() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input bit with_hold);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (with_hold && i == 5) begin
            hold_off = 1'b1;
         end
         offer_random_reading();
      end
      stop_readings();
      wait_drained();
   endtask

   // Receiver: ready is driven in stretches of random length, or held high while idling is
   // off. When asked, it holds off for HOLD_CYCLES, counted here, while the sender keeps
   // offering readings.
   initial begin
      int p;
      int span;
      bit level;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) begin
         @(posedge clock);
      end
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if (!idle_on) begin
               level = 1'b1;
               span  = 1;
            end else begin
               p = $urandom_range(0, 99);
               if (p < 65) begin
                  level = 1'b1;
                  span  = $urandom_range(1, 8);
               end else if (p < 93) begin
                  level = 1'b0;
                  span  = $urandom_range(1, 3);
               end else begin
                  level = 1'b0;
                  span  = $urandom_range(10, 40);
               end
            end
            rsp_bus.ready <= level;
            repeat (span) @(posedge clock);
         end
      end
   end

   // Main stimulus.
   initial begin
      // Directed readings at the reset configuration (regression from 20.0 C
      // and 40.0 %, limits 10.0 / 20.0 / 28.0 / 35.0). They cover the field
      // extremes, readings exactly at and just below each entry limit, the
      // pass-through temperature at and beyond the low clip, a regression that
      // clips high, and pass-through values either side of every threshold.
      int directed_temp  [24] = '{-400, 800, -1024, 1023, 200, 199, 200, -1000,
                                  -1001, 99, 100, 199, 279, 280, 349, 350,
                                  300, 350, 270, 400, 800, 0, -1, 1023};
      int directed_humid [24] = '{0, 1000, 0, 1023, 400, 400, 399, 500,
                                  500, 0, 0, 1000, 0, 0, 0, 0,
                                  500, 800, 600, 1000, 0, 1000, 1023, 0};
      int cold;
      int cool;
      int comfortable;
      int warm;

      board = new();
      req_bus.valid              <= 1'b0;
      req_bus.temperature_tenths <= '0;
      req_bus.humidity_tenths    <= '0;
      csr_bus.valid              <= 1'b0;
      csr_bus.index              <= CSR_VALID_TEMP_MIN;
      csr_bus.data               <= '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 24; i++) begin
         offer_reading(directed_temp[i], directed_humid[i]);
      end
      stop_readings();
      wait_drained();

      // Random ascending thresholds; the long receiver hold-off happens here.
      cold        = $urandom_range(0, 1200) - 1000;
      cool        = cold + $urandom_range(0, 300);
      comfortable = cool + $urandom_range(0, 300);
      warm        = comfortable + $urandom_range(0, 400);
      program_all($urandom_range(0, 1200) - 400, $urandom_range(0, 1000),
                  cold, cool, comfortable, warm);
      run_random_phase(1'b1);

      // Lowest documented entry limits, so nearly every reading takes the
      // regression, with thresholds spread over the whole range.
      program_all(-400, 0, -1000, 0, 1000, 2000);
      run_random_phase(1'b0);

      // Highest documented entry limits and coincident top thresholds, run
      // without any idling on either side.
      idle_on = 1'b0;
      program_all(800, 1000, 2000, 2000, 2000, 2000);
      run_random_phase(1'b0);
      idle_on = 1'b1;

      // Patterns beyond the documented ranges and thresholds out of order.
      program_all(-1024, 1023, 2047, -2048, 0, -1);
      run_random_phase(1'b0);

      // Raw register patterns, including writes to indexes with no register
      // behind them, which must leave the configuration untouched.
      write_csr(CSR_VALID_TEMP_MIN, $urandom_range(0, 4095));
      write_csr(CSR_VALID_HUMIDITY_MIN, $urandom_range(0, 4095));
      write_csr(CSR_COLD_LIMIT, $urandom_range(0, 4095));
      write_csr(CSR_COOL_LIMIT, $urandom_range(0, 4095));
      write_csr(CSR_COMFORTABLE_LIMIT, $urandom_range(0, 4095));
      write_csr(CSR_WARM_LIMIT, $urandom_range(0, 4095));
      write_csr(CSR_UNMAPPED_LO, $urandom_range(0, 4095));
      write_csr(CSR_UNMAPPED_HI, $urandom_range(0, 4095));
      finish_csr();
      run_random_phase(1'b0);

      if (board.mismatch_count == 0) begin
         $display("heat_index_comfort_classifier_tb passed");
      end else begin
         $display("heat_index_comfort_classifier_tb failed");
      end
      $finish;
   end

endmodule
